// ----- rtl/core/gsop1_pkg.sv -----
// Shared types and constants for the scalar single-source execute core.
package gsop1_pkg;

   localparam logic [2:0] OP_MOV32        = 3'd0;
   localparam logic [2:0] OP_MOV64        = 3'd1;
   localparam logic [2:0] OP_NOT32        = 3'd2;
   localparam logic [2:0] OP_SWAP_PC      = 3'd3;
   localparam logic [2:0] OP_AND_SAVEEXEC = 3'd4;

   localparam logic [7:0] LITERAL_SEL     = 8'hFF;
   localparam logic [3:0] INSTR_BYTES_LIT = 4'd8;
   localparam logic [3:0] INSTR_BYTES_STD = 4'd4;
   localparam logic [31:0] PC_STEP        = 32'd4;

   typedef struct packed {
      logic [2:0]  operation;
      logic [7:0]  src_index;
      logic [6:0]  dst_index;
      logic [31:0] literal;
      logic [31:0] current_pc;
   } req_type;

   typedef struct packed {
      logic [3:0]  instr_bytes;
      logic        branch_taken;
      logic [31:0] branch_target;
      logic        scc_out;
      logic [63:0] exec_out;
      logic        illegal;
   } rsp_type;

endpackage

// ----- rtl/core/gpu_scalar_sop1_execute_core.sv -----
// Scalar single-source execute core: register file, exec/scc state and op logic.
//
// Usage:
//   req channel  : one instruction transaction (op, source, destination, literal, pc).
//   rsp channel  : one result transaction per instruction (length, branch, scc, exec,
//                  illegal flag).
//   A transaction moves on a rising edge with valid high and stall low.
// Pipeline: a request passes the read stage, then the result register, before rsp valid
//   rises; a rsp stall can hold it in either. Throughput: one instruction per cycle
//   while rsp is not stalled, bounded by the single write port of each register-file bank.
// Register file: two banks of (REG_COUNT+1)/2 words, read at acceptance with
//   registered read data; the write of the instruction leaving the read stage
//   is forwarded to the instruction entering it. Register zero, the exec pair
//   and scc live in flops so that all five writes of one instruction land in
//   the same cycle.
// Reset: synchronous; pipeline empties, every register reads as zero (per-entry
//   valid bits, no clearing pass).
// Stall: a stalled rsp holds its result; the read stage then holds too and
//   req_stall rises, so no transaction is lost or repeated.
module gpu_scalar_sop1_execute_core #(
   parameter int REG_COUNT  = 256,
   parameter int EXEC_INDEX = 126,
   parameter int SCC_INDEX  = 253
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  gsop1_pkg::req_type req_payload,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output gsop1_pkg::rsp_type rsp_payload
);
   import gsop1_pkg::*;

   localparam int IDX_W      = $clog2(REG_COUNT);
   localparam int BANK_AW    = IDX_W - 1;
   localparam int BANK_DEPTH = (REG_COUNT + 1) / 2;
   localparam int EXEC_LO    = EXEC_INDEX % REG_COUNT;
   localparam int EXEC_HI    = (EXEC_INDEX + 1) % REG_COUNT;
   localparam int SCC_POS    = SCC_INDEX % REG_COUNT;
   localparam int NUM_SLOTS  = 4;
   localparam int NUM_WR     = 5;

   // Flop-held registers: zero (wrap target of a source pair), exec low/high, scc.
   localparam logic [IDX_W-1:0] SLOT_IDX [NUM_SLOTS] = '{
      IDX_W'(0), IDX_W'(EXEC_LO), IDX_W'(EXEC_HI), IDX_W'(SCC_POS)
   };
   localparam int SLOT_EXEC_LO = 1;
   localparam int SLOT_EXEC_HI = 2;
   localparam int SLOT_SCC     = 3;

   // Handshake / pipeline control
   logic    s1_vld_ff, s1_vld_in;
   logic    out_vld_ff, out_vld_in;
   logic    accept, commit;
   req_type s1_req_ff;
   rsp_type rsp_ff, rsp_in;

   assign commit    = s1_vld_ff && (!out_vld_ff || !rsp_stall);
   assign req_stall = s1_vld_ff && !commit;
   assign accept    = req_valid && !req_stall;
   assign rsp_valid   = out_vld_ff;
   assign rsp_payload = rsp_ff;

   // Source index wrap at acceptance (values stay below twice REG_COUNT)
   logic [8:0]       src_sum_lo, src_sum_hi;
   logic [IDX_W-1:0] acc_lo_idx, acc_hi_idx;
   logic [IDX_W-1:0] s1_lo_idx_ff, s1_hi_idx_ff;

   always_comb begin
      src_sum_lo = {1'b0, req_payload.src_index};
      src_sum_hi = {1'b0, req_payload.src_index} + 9'd1;
      acc_lo_idx = (src_sum_lo >= 9'(REG_COUNT)) ? IDX_W'(src_sum_lo - 9'(REG_COUNT))
                                                 : IDX_W'(src_sum_lo);
      acc_hi_idx = (src_sum_hi >= 9'(REG_COUNT)) ? IDX_W'(src_sum_hi - 9'(REG_COUNT))
                                                 : IDX_W'(src_sum_hi);
   end

   // Bank read addresses: source low word from its parity bank, high from the other
   logic [BANK_AW-1:0] rd_addr [2];
   always_comb begin
      for (int b = 0; b < 2; b++) begin
         rd_addr[b] = (acc_lo_idx[0] == b[0]) ? acc_lo_idx[IDX_W-1:1]
                                              : acc_hi_idx[IDX_W-1:1];
      end
   end

   // Register-file banks with forwarding of the last committed write
   logic               wr_en   [2];
   logic [BANK_AW-1:0] wr_addr [2];
   logic [31:0]        wr_data [2];
   logic [31:0]        bank_q_ff   [2];
   logic               bank_vld_ff [2];
   logic               fwd_en_ff   [2];
   logic [BANK_AW-1:0] fwd_addr_ff [2];
   logic [31:0]        fwd_data_ff [2];

   for (genvar b = 0; b < 2; b++) begin : g_bank
      logic [31:0] mem_ff   [BANK_DEPTH];
      logic        entry_ff [BANK_DEPTH];

      always_ff @(posedge clock) begin
         if (accept) begin
            bank_q_ff[b] <= mem_ff[rd_addr[b]];
         end
         if (commit && wr_en[b]) begin
            mem_ff[wr_addr[b]] <= wr_data[b];
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            for (int i = 0; i < BANK_DEPTH; i++) begin
               entry_ff[i] <= 1'b0;
            end
            bank_vld_ff[b] <= 1'b0;
            fwd_en_ff[b]   <= 1'b0;
         end else begin
            if (accept) begin
               bank_vld_ff[b] <= entry_ff[rd_addr[b]];
            end
            if (commit) begin
               if (wr_en[b]) begin
                  entry_ff[wr_addr[b]] <= 1'b1;
               end
               fwd_en_ff[b] <= wr_en[b];
            end
         end
      end

      always_ff @(posedge clock) begin
         if (commit) begin
            fwd_addr_ff[b] <= wr_addr[b];
            fwd_data_ff[b] <= wr_data[b];
         end
      end
   end

   // Flop-held special registers
   logic [31:0] slot_ff [NUM_SLOTS];
   logic [31:0] slot_in [NUM_SLOTS];

   // Operand read in the read stage
   logic               lo_spec, hi_spec;
   logic [31:0]        lo_spec_val, hi_spec_val;
   logic [BANK_AW-1:0] lo_addr, hi_addr;
   logic               lo_bank, hi_bank;
   logic [31:0]        rd_lo, rd_hi;

   always_comb begin
      lo_spec     = 1'b0;
      hi_spec     = 1'b0;
      lo_spec_val = '0;
      hi_spec_val = '0;
      for (int s = NUM_SLOTS - 1; s >= 0; s--) begin
         if (SLOT_IDX[s] == s1_lo_idx_ff) begin
            lo_spec     = 1'b1;
            lo_spec_val = slot_ff[s];
         end
         if (SLOT_IDX[s] == s1_hi_idx_ff) begin
            hi_spec     = 1'b1;
            hi_spec_val = slot_ff[s];
         end
      end
      lo_bank = s1_lo_idx_ff[0];
      hi_bank = ~s1_lo_idx_ff[0];
      lo_addr = s1_lo_idx_ff[IDX_W-1:1];
      hi_addr = s1_hi_idx_ff[IDX_W-1:1];

      if (lo_spec) begin
         rd_lo = lo_spec_val;
      end else if (fwd_en_ff[lo_bank] && fwd_addr_ff[lo_bank] == lo_addr) begin
         rd_lo = fwd_data_ff[lo_bank];
      end else begin
         rd_lo = bank_vld_ff[lo_bank] ? bank_q_ff[lo_bank] : 32'd0;
      end

      if (hi_spec) begin
         rd_hi = hi_spec_val;
      end else if (fwd_en_ff[hi_bank] && fwd_addr_ff[hi_bank] == hi_addr) begin
         rd_hi = fwd_data_ff[hi_bank];
      end else begin
         rd_hi = bank_vld_ff[hi_bank] ? bank_q_ff[hi_bank] : 32'd0;
      end
   end

   // Operation decode: five ordered writes, later ones win
   logic             w_en   [NUM_WR];
   logic [IDX_W-1:0] w_idx  [NUM_WR];
   logic [31:0]      w_data [NUM_WR];
   logic             use_lit;
   logic [31:0]      src_val, not_val, and_lo, and_hi, elo, ehi;
   logic [7:0]       dst_sum;
   logic [IDX_W-1:0] dst_lo, dst_hi;
   logic             taken, illegal;
   logic [31:0]      target;

   always_comb begin
      use_lit = (s1_req_ff.src_index == LITERAL_SEL);
      src_val = use_lit ? s1_req_ff.literal : rd_lo;
      not_val = ~src_val;
      elo     = slot_ff[SLOT_EXEC_LO];
      ehi     = slot_ff[SLOT_EXEC_HI];
      and_lo  = rd_lo & elo;
      and_hi  = rd_hi & ehi;
      dst_sum = {1'b0, s1_req_ff.dst_index} + 8'd1;
      dst_lo  = IDX_W'(s1_req_ff.dst_index);
      dst_hi  = (dst_sum == 8'(REG_COUNT)) ? IDX_W'(0) : IDX_W'(dst_sum);

      w_idx[0] = dst_lo;
      w_idx[1] = dst_hi;
      w_idx[2] = SLOT_IDX[SLOT_EXEC_LO];
      w_idx[3] = SLOT_IDX[SLOT_EXEC_HI];
      w_idx[4] = SLOT_IDX[SLOT_SCC];
      for (int w = 0; w < NUM_WR; w++) begin
         w_en[w]   = 1'b0;
         w_data[w] = '0;
      end
      taken   = 1'b0;
      illegal = 1'b0;
      target  = '0;

      unique case (s1_req_ff.operation)
         OP_MOV32: begin
            w_en[0]   = 1'b1;
            w_data[0] = src_val;
         end
         OP_MOV64: begin
            w_en[0]   = 1'b1;
            w_data[0] = src_val;
            w_en[1]   = 1'b1;
            w_data[1] = use_lit ? 32'd0 : rd_hi;
         end
         OP_NOT32: begin
            w_en[0]   = 1'b1;
            w_data[0] = not_val;
            w_en[4]   = 1'b1;
            w_data[4] = {31'd0, |not_val};
         end
         OP_SWAP_PC: begin
            if (use_lit) begin
               illegal = 1'b1;
            end else begin
               w_en[0]   = 1'b1;
               w_data[0] = s1_req_ff.current_pc + PC_STEP;
               w_en[1]   = 1'b1;
               w_data[1] = 32'd0;
               taken     = 1'b1;
               target    = rd_lo;
            end
         end
         OP_AND_SAVEEXEC: begin
            if (use_lit) begin
               illegal = 1'b1;
            end else begin
               w_en[0]   = 1'b1;
               w_data[0] = elo;
               w_en[1]   = 1'b1;
               w_data[1] = ehi;
               w_en[2]   = 1'b1;
               w_data[2] = and_lo;
               w_en[3]   = 1'b1;
               w_data[3] = and_hi;
               w_en[4]   = 1'b1;
               w_data[4] = {31'd0, |(and_lo | and_hi)};
            end
         end
         default: begin
         end
      endcase
   end

   // Bank write ports: the destination pair always spans both banks
   always_comb begin
      for (int b = 0; b < 2; b++) begin
         if (dst_lo[0] == b[0]) begin
            wr_en[b]   = w_en[0];
            wr_addr[b] = dst_lo[IDX_W-1:1];
            wr_data[b] = w_data[0];
         end else begin
            wr_en[b]   = w_en[1];
            wr_addr[b] = dst_hi[IDX_W-1:1];
            wr_data[b] = w_data[1];
         end
      end
   end

   // Special registers after this instruction
   always_comb begin
      for (int s = 0; s < NUM_SLOTS; s++) begin
         slot_in[s] = slot_ff[s];
         for (int w = 0; w < NUM_WR; w++) begin
            if (w_en[w] && w_idx[w] == SLOT_IDX[s]) begin
               slot_in[s] = w_data[w];
            end
         end
      end
   end

   always_comb begin
      rsp_in.instr_bytes   = use_lit ? INSTR_BYTES_LIT : INSTR_BYTES_STD;
      rsp_in.branch_taken  = taken;
      rsp_in.branch_target = target;
      rsp_in.scc_out       = |slot_in[SLOT_SCC];
      rsp_in.exec_out      = {slot_in[SLOT_EXEC_HI], slot_in[SLOT_EXEC_LO]};
      rsp_in.illegal       = illegal;
   end

   assign s1_vld_in  = accept ? 1'b1 : (commit ? 1'b0 : s1_vld_ff);
   assign out_vld_in = commit ? 1'b1 : (rsp_stall ? out_vld_ff : 1'b0);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
         for (int s = 0; s < NUM_SLOTS; s++) begin
            slot_ff[s] <= '0;
         end
      end else begin
         s1_vld_ff  <= s1_vld_in;
         out_vld_ff <= out_vld_in;
         if (commit) begin
            for (int s = 0; s < NUM_SLOTS; s++) begin
               slot_ff[s] <= slot_in[s];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_req_ff    <= req_payload;
         s1_lo_idx_ff <= acc_lo_idx;
         s1_hi_idx_ff <= acc_hi_idx;
      end
      if (commit) begin
         rsp_ff <= rsp_in;
      end
   end

endmodule

// ----- verif/gpu_scalar_sop1_execute_core_tb.sv -----
// Self-checking testbench for the scalar single-source execute core.
module gpu_scalar_sop1_execute_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import gsop1_pkg::*;

   // Block configuration, passed to the instance and mirrored by the predictor.
   localparam int REG_COUNT = 256;
   localparam int EXEC_IDX  = 126;
   localparam int SCC_IDX   = 253;

   // Opcodes the block does not decode: no state change, no flags.
   localparam logic [2:0] OP_UNDEF_FIRST = 3'd5;
   localparam logic [2:0] OP_UNDEF_LAST  = 3'd7;

   localparam int RESET_CYCLES     = 11;
   localparam int MAX_IDLE         = 11;
   localparam int RSP_HOLD_CYCLES  = 80;    // long receiver hold-off for the fill test
   localparam int FILL_ITEMS       = 40;
   localparam int RANDOM_ITEMS     = 1880;
   localparam int IDLE_PHASE_ITEMS = 150;   // idle mode is redrawn every this many items
   localparam int DRAIN_CYCLES     = 10;    // margin for a stray result to show up
   localparam int LIMIT_CYCLES     = 400000;
   localparam int MAX_REPORTS      = 10;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_payload;
   logic    rsp_valid;
   logic    rsp_stall;
   rsp_type rsp_payload;

   // Predictor state: the scalar file, exec pair and scc included.
   logic [31:0] sop1_regs [REG_COUNT];
   rsp_type     sop1_expected_q [$];
   rsp_type     sop1_want;

   int unsigned cycle_count;
   int unsigned mismatch_count;

   // Idle controls shared with the driver and the receiver.
   bit req_idle_on;
   bit rsp_idle_on;
   bit rsp_hold_pending;

   gpu_scalar_sop1_execute_core #(
      .REG_COUNT  (REG_COUNT),
      .EXEC_INDEX (EXEC_IDX),
      .SCC_INDEX  (SCC_IDX)
   ) uut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   always begin
      clock = 1'b0;
      #2;
      clock = 1'b1;
      #2;
   end

   // Watchdog: a hung handshake ends the run as a failure.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == LIMIT_CYCLES) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // Executes one instruction against the predictor's file and returns the
   // result it should produce. All sources are read before any write; writes
   // land as dst lo, dst hi, exec lo, exec hi, scc so the later one wins.
   // With REG_COUNT = 256 the 8-bit index arithmetic gives the wrap for free.
   function automatic rsp_type execute_sop1(input req_type instr);
      rsp_type     res;
      logic [7:0]  src_lo;
      logic [7:0]  src_hi;
      logic [7:0]  dst_lo;
      logic [7:0]  dst_hi;
      logic        use_lit;
      logic [31:0] lo;
      logic [31:0] hi;
      logic [31:0] exec_lo;
      logic [31:0] exec_hi;

      src_lo  = instr.src_index;
      src_hi  = instr.src_index + 8'd1;
      dst_lo  = {1'b0, instr.dst_index};
      dst_hi  = dst_lo + 8'd1;
      use_lit = (instr.src_index == LITERAL_SEL);
      res     = '0;

      case (instr.operation)
         OP_MOV32: begin
            sop1_regs[dst_lo] = use_lit ? instr.literal : sop1_regs[src_lo];
         end
         OP_MOV64: begin
            // a literal only fills the low word
            lo = use_lit ? instr.literal : sop1_regs[src_lo];
            hi = use_lit ? 32'd0 : sop1_regs[src_hi];
            sop1_regs[dst_lo] = lo;
            sop1_regs[dst_hi] = hi;
         end
         OP_NOT32: begin
            lo = ~(use_lit ? instr.literal : sop1_regs[src_lo]);
            sop1_regs[dst_lo]  = lo;
            sop1_regs[SCC_IDX] = {31'd0, lo != 32'd0};
         end
         OP_SWAP_PC: begin
            if (use_lit) begin
               res.illegal = 1'b1;
            end else begin
               res.branch_target = sop1_regs[src_lo];
               res.branch_taken  = 1'b1;
               sop1_regs[dst_lo] = instr.current_pc + PC_STEP;
               sop1_regs[dst_hi] = 32'd0;
            end
         end
         OP_AND_SAVEEXEC: begin
            if (use_lit) begin
               res.illegal = 1'b1;
            end else begin
               exec_lo = sop1_regs[EXEC_IDX];
               exec_hi = sop1_regs[EXEC_IDX + 1];
               lo = sop1_regs[src_lo] & exec_lo;
               hi = sop1_regs[src_hi] & exec_hi;
               sop1_regs[dst_lo]       = exec_lo;
               sop1_regs[dst_hi]       = exec_hi;
               sop1_regs[EXEC_IDX]     = lo;
               sop1_regs[EXEC_IDX + 1] = hi;
               sop1_regs[SCC_IDX]      = {31'd0, (lo | hi) != 32'd0};
            end
         end
         default: begin
         end
      endcase

      res.instr_bytes = use_lit ? INSTR_BYTES_LIT : INSTR_BYTES_STD;
      res.scc_out     = (sop1_regs[SCC_IDX] != 32'd0);
      res.exec_out    = {sop1_regs[EXEC_IDX + 1], sop1_regs[EXEC_IDX]};
      return res;
   endfunction

   function automatic req_type make_sop1(input logic [2:0] op, input logic [7:0] src,
                                         input logic [6:0] dst, input logic [31:0] lit,
                                         input logic [31:0] pc);
      req_type instr;
      instr.operation  = op;
      instr.src_index  = src;
      instr.dst_index  = dst;
      instr.literal    = lit;
      instr.current_pc = pc;
      return instr;
   endfunction

   // Drives one request transaction. Called at a falling edge, returns at one.
   // Expectation is queued at the accepting edge, in acceptance order.
   task automatic send_instr(input req_type instr);
      int unsigned gap;
      gap = req_idle_on ? $urandom_range(0, MAX_IDLE) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= instr;
      @(posedge clock);
      while (req_stall !== 1'b0) @(posedge clock);
      sop1_expected_q.push_back(execute_sop1(instr));
      @(negedge clock);
   endtask

   // Drop valid and wait for every outstanding result.
   task automatic finish_phase();
      req_valid <= 1'b0;
      while (sop1_expected_q.size() != 0) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic check_field(input string field, input logic [63:0] want,
                              input logic [63:0] got);
      if (got !== want) begin
         mismatch_count++;
         if (mismatch_count <= MAX_REPORTS)
            $display("mismatch %s at cycle %0d: expected %h, got %h",
                     field, cycle_count, want, got);
      end
   endtask

   // Response checker: every accepted result against the oldest expectation.
   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         if (sop1_expected_q.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
               $display("unexpected result at cycle %0d: %h", cycle_count, rsp_payload);
         end else begin
            sop1_want = sop1_expected_q.pop_front();
            check_field("instr_bytes", 64'(sop1_want.instr_bytes), 64'(rsp_payload.instr_bytes));
            check_field("branch_taken", 64'(sop1_want.branch_taken),
                        64'(rsp_payload.branch_taken));
            check_field("branch_target", 64'(sop1_want.branch_target),
                        64'(rsp_payload.branch_target));
            check_field("scc_out", 64'(sop1_want.scc_out), 64'(rsp_payload.scc_out));
            check_field("exec_out", sop1_want.exec_out, rsp_payload.exec_out);
            check_field("illegal", 64'(sop1_want.illegal), 64'(rsp_payload.illegal));
         end
      end
   end

   // Receiver: per result a random stall while rsp_idle_on is set, plus a long
   // hold-off requested by a test and counted here so the pipeline backs up.
   initial begin : rsp_side
      int unsigned hold_left;
      int unsigned stall_left;
      bit          took;
      rsp_stall  = 1'b0;
      hold_left  = 0;
      stall_left = 0;
      forever begin
         @(posedge clock);
         took = (rsp_valid === 1'b1) && (rsp_stall === 1'b0) && !reset;
         @(negedge clock);
         if (rsp_hold_pending) begin
            hold_left        = RSP_HOLD_CYCLES;
            rsp_hold_pending = 1'b0;
         end
         if (took)
            stall_left = rsp_idle_on ? $urandom_range(0, MAX_IDLE) : 0;
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // Directed: field extremes, every opcode and the corner cases (literal on a
   // 64-bit move, literal where forbidden, undecoded opcodes, top source pair,
   // overlapping dst/exec writes, return address wrap).
   task automatic test_directed_ops();
      req_idle_on = 1'b1;
      rsp_idle_on = 1'b1;
      send_instr(make_sop1(OP_MOV32, LITERAL_SEL, 7'd0, 32'hFFFF_FFFF, $urandom));
      send_instr(make_sop1(OP_MOV32, LITERAL_SEL, 7'd127, 32'h0000_0000, $urandom));
      // literal on mov64 lands in exec lo, exec hi forced to zero
      send_instr(make_sop1(OP_MOV64, LITERAL_SEL, 7'(EXEC_IDX), 32'hA5A5_5A5A, $urandom));
      send_instr(make_sop1(OP_MOV32, LITERAL_SEL, 7'(EXEC_IDX + 1), 32'hFFFF_0000, $urandom));
      send_instr(make_sop1(OP_MOV64, 8'd0, 7'd10, $urandom, $urandom));
      // not of all ones gives zero and clears scc, then the reverse
      send_instr(make_sop1(OP_NOT32, LITERAL_SEL, 7'd3, 32'hFFFF_FFFF, $urandom));
      send_instr(make_sop1(OP_NOT32, 8'd3, 7'd4, $urandom, $urandom));
      send_instr(make_sop1(OP_MOV32, 8'(SCC_IDX), 7'd1, $urandom, $urandom));
      // return address wraps past 2^32
      send_instr(make_sop1(OP_SWAP_PC, 8'd4, 7'd20, $urandom, 32'hFFFF_FFFC));
      send_instr(make_sop1(OP_SWAP_PC, LITERAL_SEL, 7'd22, $urandom, $urandom));
      send_instr(make_sop1(OP_AND_SAVEEXEC, LITERAL_SEL, 7'd24, $urandom, $urandom));
      send_instr(make_sop1(OP_AND_SAVEEXEC, 8'd0, 7'd30, $urandom, $urandom));
      // source pair is 254 and 255, the top two; dst overlaps exec, exec wins
      send_instr(make_sop1(OP_AND_SAVEEXEC, 8'd254, 7'(EXEC_IDX), $urandom, $urandom));
      send_instr(make_sop1(OP_MOV64, 8'd30, 7'(EXEC_IDX), $urandom, $urandom));
      // dst hi aliases exec lo
      send_instr(make_sop1(OP_AND_SAVEEXEC, 8'd10, 7'(EXEC_IDX - 1), $urandom, $urandom));
      send_instr(make_sop1(OP_SWAP_PC, 8'(EXEC_IDX), 7'(EXEC_IDX), $urandom, 32'd0));
      send_instr(make_sop1(OP_MOV64, 8'(EXEC_IDX), 7'd40, $urandom, $urandom));
      send_instr(make_sop1(OP_UNDEF_FIRST, LITERAL_SEL, 7'd0, $urandom, $urandom));
      send_instr(make_sop1(OP_UNDEF_FIRST + 3'd1, 8'd4, 7'd127, $urandom, $urandom));
      send_instr(make_sop1(OP_UNDEF_LAST, 8'd254, 7'(EXEC_IDX), $urandom, $urandom));
      send_instr(make_sop1(OP_NOT32, 8'd254, 7'd127, $urandom, $urandom));
      send_instr(make_sop1(OP_MOV32, 8'd2, 7'd5, $urandom, 32'hFFFF_FFFF));
   endtask

   // Receiver holds off for a long stretch while the driver keeps offering
   // back-to-back transactions; req_stall must rise and nothing may be lost.
   task automatic test_rsp_backpressure();
      req_idle_on      = 1'b0;
      rsp_idle_on      = 1'b0;
      rsp_hold_pending = 1'b1;
      for (int unsigned n = 0; n < FILL_ITEMS; n++)
         send_instr(make_sop1(3'($urandom_range(0, int'(OP_AND_SAVEEXEC))),
                              8'($urandom_range(0, 15)), 7'($urandom_range(0, 15)),
                              $urandom, $urandom));
   endtask

   // Random stream biased toward registers that get written, the exec pair,
   // scc and the literal; idle modes are redrawn every IDLE_PHASE_ITEMS items.
   task automatic test_random_stream(input int unsigned count);
      req_type     instr;
      int unsigned pick;
      for (int unsigned n = 0; n < count; n++) begin
         if (n % IDLE_PHASE_ITEMS == 0) begin
            pick        = $urandom_range(0, 3);
            req_idle_on = pick[0];
            rsp_idle_on = pick[1];
         end

         pick = $urandom_range(0, 19);
         if (pick == 19)
            instr.operation = 3'($urandom_range(int'(OP_UNDEF_FIRST), int'(OP_UNDEF_LAST)));
         else
            instr.operation = 3'(pick % (int'(OP_AND_SAVEEXEC) + 1));

         case ($urandom_range(0, 7))
            0:       instr.src_index = LITERAL_SEL;
            1:       instr.src_index = 8'(EXEC_IDX + $urandom_range(0, 1));
            2:       instr.src_index = 8'(SCC_IDX);
            3, 4:    instr.src_index = 8'($urandom_range(0, 15));
            default: instr.src_index = 8'($urandom_range(0, 254));
         endcase

         pick = $urandom_range(0, 9);
         if (pick < 5)
            instr.dst_index = 7'($urandom_range(0, 15));
         else if (pick < 7)
            instr.dst_index = 7'($urandom_range(124, 127));
         else
            instr.dst_index = 7'($urandom_range(0, 127));

         case ($urandom_range(0, 7))
            0:       instr.literal = '1;
            1:       instr.literal = '0;
            default: instr.literal = $urandom;
         endcase

         if ($urandom_range(0, 15) == 0)
            instr.current_pc = 32'hFFFF_FFFC + 32'($urandom_range(0, 3));
         else
            instr.current_pc = $urandom;

         send_instr(instr);
      end
   endtask

   initial begin
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_payload      = '0;
      req_idle_on      = 1'b0;
      rsp_idle_on      = 1'b0;
      rsp_hold_pending = 1'b0;
      cycle_count      = 0;
      mismatch_count   = 0;
      foreach (sop1_regs[i]) sop1_regs[i] = '0;

      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_directed_ops();
      finish_phase();
      test_rsp_backpressure();
      finish_phase();
      test_random_stream(RANDOM_ITEMS);
      finish_phase();

      // catch any stray result after the last expected one
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && sop1_expected_q.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
